// ----- rtl/core/aigsim_pkg.sv -----
package aigsim_pkg;

    localparam int unsigned MAX_NODES     = 4096;
    localparam int unsigned PATTERN_WIDTH = 32;
    localparam int unsigned ID_WIDTH      = 12;
    localparam int unsigned COUNT_WIDTH   = 6;

    localparam logic [PATTERN_WIDTH-1:0] CONST_NODE_WORD = '1;

    typedef enum logic [1:0] {
        KIND_INPUT  = 2'd0,
        KIND_AND    = 2'd1,
        KIND_OUTPUT = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind                    kind;
        logic [ID_WIDTH-1:0]      node_id;
        logic [PATTERN_WIDTH-1:0] pattern_word;
        logic [ID_WIDTH-1:0]      left_id;
        logic                     left_invert;
        logic [ID_WIDTH-1:0]      right_id;
        logic                     right_invert;
        logic [COUNT_WIDTH-1:0]   pattern_count;
    } t_req;

    typedef struct packed {
        logic [PATTERN_WIDTH-1:0] output_bits;
        logic [COUNT_WIDTH-1:0]   bit_count;
    } t_rsp;

endpackage

// ----- rtl/core/aigsim_node_ram.sv -----
module aigsim_node_ram #(
    parameter int unsigned DEPTH = aigsim_pkg::MAX_NODES
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic [$clog2(DEPTH)-1:0]             i_rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0]             i_rd_addr_b,
    output logic [aigsim_pkg::PATTERN_WIDTH-1:0] o_rd_data_a,
    output logic [aigsim_pkg::PATTERN_WIDTH-1:0] o_rd_data_b,
    input  logic                                 i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]             i_wr_addr,
    input  logic [aigsim_pkg::PATTERN_WIDTH-1:0] i_wr_data
);

    logic [aigsim_pkg::PATTERN_WIDTH-1:0] r_mem [DEPTH];
    logic [aigsim_pkg::PATTERN_WIDTH-1:0] r_q_a;
    logic [aigsim_pkg::PATTERN_WIDTH-1:0] r_q_b;
    logic [aigsim_pkg::PATTERN_WIDTH-1:0] r_fwd_data;
    logic                                 r_fwd_a;
    logic                                 r_fwd_b;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_q_a      <= r_mem[i_rd_addr_a];
        r_q_b      <= r_mem[i_rd_addr_b];
        r_fwd_data <= i_wr_data;
    end

    // a read that meets a write to the same entry sees old data: bypass it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_a <= 1'b0;
            r_fwd_b <= 1'b0;
        end else begin
            r_fwd_a <= i_wr_en && (i_wr_addr == i_rd_addr_a);
            r_fwd_b <= i_wr_en && (i_wr_addr == i_rd_addr_b);
        end
    end

    assign o_rd_data_a = r_fwd_a ? r_fwd_data : r_q_a;
    assign o_rd_data_b = r_fwd_b ? r_fwd_data : r_q_b;

endmodule

// ----- rtl/core/aig_bit_parallel_simulator.sv -----
// Bit-parallel and-inverter graph simulator, 32 patterns per word. Objects are
// sent in topological order, one request per cycle: busy stays low, so a request
// is taken at every edge where start is high. Each request reads both fanin
// words from the node memory (registered synchronous read) and the following
// cycle computes and writes back; a write that collides with the next request's
// read is bypassed, so dependent nodes may follow back to back. An output object
// gives its result through the s1 stage and the output register, as a one-cycle
// pulse on o_valid that cannot be held off. Node id 0 reads as all ones; ids at or
// above MAX_NODES are not stored and read as zero. Node words need no clearing pass,
// but a node must be written before it is read.
module aig_bit_parallel_simulator #(
    parameter int unsigned MAX_NODES = aigsim_pkg::MAX_NODES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  aigsim_pkg::t_req  i_req,
    output logic              o_valid,
    output aigsim_pkg::t_rsp  o_rsp
);

    localparam int unsigned AW = $clog2(MAX_NODES);
    localparam int unsigned PW = aigsim_pkg::PATTERN_WIDTH;
    localparam int unsigned IW = aigsim_pkg::ID_WIDTH;
    localparam int unsigned CW = aigsim_pkg::COUNT_WIDTH;

    logic              r_s1_valid;
    aigsim_pkg::t_req  r_s1_req;
    logic              r_valid;
    aigsim_pkg::t_rsp  r_rsp;
    logic              n_valid;
    aigsim_pkg::t_rsp  n_rsp;

    logic [AW+IW-1:0]  left_ext;
    logic [AW+IW-1:0]  right_ext;
    logic [AW+IW-1:0]  node_ext;
    logic [PW-1:0]     ram_a;
    logic [PW-1:0]     ram_b;
    logic [PW-1:0]     left_word;
    logic [PW-1:0]     right_word;
    logic              wr_en;
    logic [PW-1:0]     wr_data;
    logic [CW-1:0]     count;
    logic [CW-1:0]     shift;

    assign busy = 1'b0;

    // zero-extend ids so the address works for any depth
    assign left_ext  = {{AW{1'b0}}, i_req.left_id};
    assign right_ext = {{AW{1'b0}}, i_req.right_id};
    assign node_ext  = {{AW{1'b0}}, r_s1_req.node_id};

    aigsim_node_ram #(
        .DEPTH(MAX_NODES)
    ) u_node_ram (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_addr_a (left_ext[AW-1:0]),
        .i_rd_addr_b (right_ext[AW-1:0]),
        .o_rd_data_a (ram_a),
        .o_rd_data_b (ram_b),
        .i_wr_en     (wr_en),
        .i_wr_addr   (node_ext[AW-1:0]),
        .i_wr_data   (wr_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_valid    <= 1'b0;
        end else begin
            r_s1_valid <= start && !busy;
            r_valid    <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_req <= i_req;
        r_rsp    <= n_rsp;
    end

    always_comb begin
        if (r_s1_req.left_id == '0) begin
            left_word = aigsim_pkg::CONST_NODE_WORD;
        end else if (32'(r_s1_req.left_id) >= 32'(MAX_NODES)) begin
            left_word = '0;
        end else begin
            left_word = ram_a;
        end
        left_word = left_word ^ {PW{r_s1_req.left_invert}};

        if (r_s1_req.right_id == '0) begin
            right_word = aigsim_pkg::CONST_NODE_WORD;
        end else if (32'(r_s1_req.right_id) >= 32'(MAX_NODES)) begin
            right_word = '0;
        end else begin
            right_word = ram_b;
        end
        right_word = right_word ^ {PW{r_s1_req.right_invert}};
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_data = left_word & right_word;
        n_valid = 1'b0;
        case (r_s1_req.kind)
            aigsim_pkg::KIND_INPUT: begin
                wr_en   = r_s1_valid;
                wr_data = r_s1_req.pattern_word;
            end
            aigsim_pkg::KIND_AND: begin
                wr_en = r_s1_valid;
            end
            aigsim_pkg::KIND_OUTPUT: begin
                n_valid = r_s1_valid;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
        // node 0 is constant and ids past the store are dropped
        if (r_s1_req.node_id == '0 || 32'(r_s1_req.node_id) >= 32'(MAX_NODES)) begin
            wr_en = 1'b0;
        end
    end

    // keep the first count patterns, right-aligned
    always_comb begin
        if (r_s1_req.pattern_count > CW'(PW)) begin
            count = CW'(PW);
        end else begin
            count = r_s1_req.pattern_count;
        end
        shift             = CW'(PW) - count;
        n_rsp.bit_count   = count;
        if (count == '0) begin
            n_rsp.output_bits = '0;
        end else begin
            n_rsp.output_bits = left_word >> shift;
        end
    end

    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

endmodule

// ----- bench/testbench.sv -----
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import aigsim_pkg::*;

    localparam logic [1:0] KIND_UNUSED  = 2'd3;
    localparam int         LATENCY      = 2;
    localparam int         STALL_LIMIT  = 1000;
    localparam int         RANDOM_ITEMS = 700;
    localparam int         SHOWN_ERRORS = 10;

    typedef struct {
        t_req req;
        bit   typed;
        t_rsp rsp;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    t_req i_req;
    logic o_valid;
    t_rsp o_rsp;

    aig_bit_parallel_simulator DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_valid (o_valid),
        .o_rsp   (o_rsp)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // graph state as the block should hold it
    logic [PATTERN_WIDTH-1:0] node_words [MAX_NODES];
    bit                       node_known [MAX_NODES];
    logic [ID_WIDTH-1:0]      known_ids [$];
    logic [ID_WIDTH-1:0]      recent_ids [$];

    t_rsp pending_outputs [$];
    t_row stimulus_table [$];
    int   mismatches   = 0;
    int   quiet_cycles = 0;

    function automatic logic [PATTERN_WIDTH-1:0] fanin_word(
        input logic [ID_WIDTH-1:0] id,
        input logic                invert
    );
        logic [PATTERN_WIDTH-1:0] w;
        w = (id == '0) ? CONST_NODE_WORD : node_words[id];
        return invert ? ~w : w;
    endfunction

    function automatic void store_word(
        input logic [ID_WIDTH-1:0]      id,
        input logic [PATTERN_WIDTH-1:0] w
    );
        if (id == '0)
            return;
        node_words[id] = w;
        if (!node_known[id]) begin
            node_known[id] = 1'b1;
            known_ids.push_back(id);
        end
        recent_ids.push_back(id);
        if (recent_ids.size() > 4)
            void'(recent_ids.pop_front());
    endfunction

    // returns 1 when the object produces an output word
    function automatic bit simulate_object(input t_req r, output t_rsp rsp);
        logic [PATTERN_WIDTH-1:0] w;
        logic [COUNT_WIDTH-1:0]   n;
        rsp = '0;
        case (r.kind)
            KIND_INPUT: begin
                store_word(r.node_id, r.pattern_word);
                return 1'b0;
            end
            KIND_AND: begin
                w = fanin_word(r.left_id, r.left_invert)
                    & fanin_word(r.right_id, r.right_invert);
                store_word(r.node_id, w);
                return 1'b0;
            end
            KIND_OUTPUT: begin
                w = fanin_word(r.left_id, r.left_invert);
                n = (r.pattern_count > PATTERN_WIDTH) ? COUNT_WIDTH'(PATTERN_WIDTH)
                                                      : r.pattern_count;
                rsp.output_bits = (n == '0) ? '0 : (w >> (PATTERN_WIDTH - n));
                rsp.bit_count   = n;
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    function automatic t_req make_req(
        input logic [1:0]               kind,
        input logic [ID_WIDTH-1:0]      node_id,
        input logic [PATTERN_WIDTH-1:0] word,
        input logic [ID_WIDTH-1:0]      left_id,
        input logic                     left_invert,
        input logic [ID_WIDTH-1:0]      right_id,
        input logic                     right_invert,
        input logic [COUNT_WIDTH-1:0]   count
    );
        t_req r;
        r.kind          = t_kind'(kind);
        r.node_id       = node_id;
        r.pattern_word  = word;
        r.left_id       = left_id;
        r.left_invert   = left_invert;
        r.right_id      = right_id;
        r.right_invert  = right_invert;
        r.pattern_count = count;
        return r;
    endfunction

    function automatic void add_row(input t_req r, input bit typed, input t_rsp rsp);
        t_row row;
        row.req   = r;
        row.typed = typed;
        row.rsp   = rsp;
        stimulus_table.push_back(row);
    endfunction

    function automatic logic [ID_WIDTH-1:0] pick_fanin();
        if ($urandom_range(19) == 0)
            return '0;
        if ($urandom_range(1) == 0)
            return recent_ids[$urandom_range(recent_ids.size() - 1)];
        return known_ids[$urandom_range(known_ids.size() - 1)];
    endfunction

    function automatic logic [COUNT_WIDTH-1:0] pick_count();
        if ($urandom_range(9) == 0)
            return COUNT_WIDTH'($urandom_range(63));
        return COUNT_WIDTH'($urandom_range(32, 1));
    endfunction

    // mostly well-formed graph objects; returns 0 for objects the block ignores
    function automatic bit random_object(output t_req r);
        int unsigned pick;
        r = t_req'({$urandom, $urandom, $urandom});
        pick = $urandom_range(99);
        if (known_ids.size() < 2 || pick < 20) begin
            r.kind    = KIND_INPUT;
            r.node_id = ID_WIDTH'($urandom_range(MAX_NODES - 1, 1));
        end else if (pick < 60) begin
            r.kind     = KIND_AND;
            r.node_id  = ID_WIDTH'($urandom_range(MAX_NODES - 1, 1));
            r.left_id  = pick_fanin();
            r.right_id = pick_fanin();
        end else if (pick < 96) begin
            r.kind          = KIND_OUTPUT;
            r.left_id       = pick_fanin();
            r.pattern_count = pick_count();
        end else if (pick < 98) begin
            // write to the constant node is dropped
            r.kind    = KIND_INPUT;
            r.node_id = '0;
            return 1'b0;
        end else begin
            r.kind = t_kind'(KIND_UNUSED);
            return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic send(input t_req r);
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic issue(input t_req r, input bit typed, input t_rsp typed_rsp);
        t_rsp rsp;
        send(r);
        if (simulate_object(r, rsp))
            pending_outputs.push_back(typed ? typed_rsp : rsp);
    endtask

    task automatic idle_sender(input int cycles);
        start <= 1'b0;
        i_req <= t_req'({$urandom, $urandom, $urandom});
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending_outputs.size() != 0)
            @(posedge i_clk);
    endtask

    // result checker and stall watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
        if (i_rst_n && o_valid) begin
            if (pending_outputs.size() == 0) begin
                mismatches++;
                if (mismatches <= SHOWN_ERRORS)
                    $display("unexpected output: bits %h count %0d",
                             o_rsp.output_bits, o_rsp.bit_count);
            end else begin
                if (o_rsp.output_bits !== pending_outputs[0].output_bits
                    || o_rsp.bit_count !== pending_outputs[0].bit_count) begin
                    mismatches++;
                    if (mismatches <= SHOWN_ERRORS)
                        $display("output mismatch: expected bits %h count %0d, got %h %0d",
                                 pending_outputs[0].output_bits,
                                 pending_outputs[0].bit_count,
                                 o_rsp.output_bits, o_rsp.bit_count);
                end
                void'(pending_outputs.pop_front());
            end
        end
    end

    initial begin
        t_req  r;
        t_rsp  none;
        int    sent;
        int    sender_idle;
        int    phase_items;
        int    waited;

        none         = '0;
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_req        = '0;

        // primary inputs at the extremes of the id range and of the word
        add_row(make_req(KIND_INPUT, 12'd1, 32'hFFFF_FFFF, '0, 1'b0, '0, 1'b0, '0), 1'b0,
                none);
        add_row(make_req(KIND_INPUT, 12'd4095, 32'h0, '1, 1'b1, '1, 1'b1, '1), 1'b0, none);
        add_row(make_req(KIND_INPUT, 12'd2, 32'hA5A5_0F0F, '0, 1'b0, '0, 1'b0, '0), 1'b0,
                none);
        // constant node and its complement
        add_row(make_req(KIND_OUTPUT, '0, '0, 12'd0, 1'b0, '0, 1'b0, 6'd32), 1'b1,
                '{32'hFFFF_FFFF, 6'd32});
        add_row(make_req(KIND_OUTPUT, '1, '1, 12'd0, 1'b1, '1, 1'b1, 6'd32), 1'b1,
                '{32'h0, 6'd32});
        // zero pattern count, saturated count, single pattern
        add_row(make_req(KIND_OUTPUT, '0, '0, 12'd1, 1'b0, '0, 1'b0, 6'd0), 1'b1,
                '{32'h0, 6'd0});
        add_row(make_req(KIND_OUTPUT, '0, '0, 12'd1, 1'b0, '0, 1'b0, 6'd63), 1'b1,
                '{32'hFFFF_FFFF, 6'd32});
        add_row(make_req(KIND_OUTPUT, '0, '0, 12'd1, 1'b0, '0, 1'b0, 6'd1), 1'b1,
                '{32'h1, 6'd1});
        add_row(make_req(KIND_OUTPUT, '0, '0, 12'd4095, 1'b1, '0, 1'b0, 6'd32), 1'b1,
                '{32'hFFFF_FFFF, 6'd32});
        add_row(make_req(KIND_OUTPUT, '0, '0, 12'd1, 1'b1, '0, 1'b0, 6'd33), 1'b1,
                '{32'h0, 6'd32});
        // and nodes, with dependents back to back to hit the write bypass
        add_row(make_req(KIND_AND, 12'd3, '1, 12'd2, 1'b0, 12'd4095, 1'b1, '1), 1'b0, none);
        add_row(make_req(KIND_OUTPUT, '0, '0, 12'd3, 1'b0, '0, 1'b0, 6'd16), 1'b0, none);
        add_row(make_req(KIND_AND, 12'd4, '0, 12'd0, 1'b1, 12'd1, 1'b0, '0), 1'b0, none);
        add_row(make_req(KIND_OUTPUT, '1, '1, 12'd4, 1'b0, '1, 1'b1, 6'd32), 1'b1,
                '{32'h0, 6'd32});
        add_row(make_req(KIND_AND, 12'd5, '0, 12'd3, 1'b0, 12'd2, 1'b1, '0), 1'b0, none);
        add_row(make_req(KIND_AND, 12'd6, '0, 12'd5, 1'b1, 12'd3, 1'b0, '0), 1'b0, none);
        add_row(make_req(KIND_OUTPUT, '0, '0, 12'd6, 1'b1, '0, 1'b0, 6'd31), 1'b0, none);
        add_row(make_req(KIND_AND, 12'd7, '0, 12'd0, 1'b0, 12'd0, 1'b0, '0), 1'b0, none);
        add_row(make_req(KIND_OUTPUT, '0, '0, 12'd7, 1'b0, '0, 1'b0, 6'd8), 1'b1,
                '{32'hFF, 6'd8});
        // write to the constant node changes nothing
        add_row(make_req(KIND_INPUT, 12'd0, 32'h0, '0, 1'b0, '0, 1'b0, '0), 1'b0, none);
        add_row(make_req(KIND_OUTPUT, '0, '0, 12'd0, 1'b0, '0, 1'b0, 6'd32), 1'b1,
                '{32'hFFFF_FFFF, 6'd32});
        // unused kind gives nothing and leaves node 1 alone
        add_row(make_req(KIND_UNUSED, 12'd1, 32'h0, 12'd1, 1'b1, 12'd1, 1'b1, 6'd32), 1'b0,
                none);
        add_row(make_req(KIND_OUTPUT, '0, '0, 12'd1, 1'b0, '0, 1'b0, 6'd32), 1'b1,
                '{32'hFFFF_FFFF, 6'd32});
        add_row(make_req(KIND_INPUT, 12'd2048, 32'h8000_0001, '0, 1'b0, '0, 1'b0, '0), 1'b0,
                none);
        add_row(make_req(KIND_OUTPUT, '0, '0, 12'd2048, 1'b0, '0, 1'b0, 6'd2), 1'b1,
                '{32'h2, 6'd2});

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (stimulus_table[k])
            issue(stimulus_table[k].req, stimulus_table[k].typed, stimulus_table[k].rsp);

        // hold off until the block has delivered everything
        drain();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                1:       sender_idle = 73;
                3:       sender_idle = 29;
                default: sender_idle = 0;
            endcase
            phase_items = 0;
            while (phase_items < RANDOM_ITEMS / 4) begin
                if ($urandom_range(99) < sender_idle)
                    idle_sender($urandom_range(6, 1));
                if (random_object(r))
                    phase_items++;
                issue(r, 1'b0, none);
            end
            drain();
        end

        waited = 0;
        while (pending_outputs.size() != 0 && waited < STALL_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (LATENCY + 4) @(posedge i_clk);

        if (mismatches == 0 && pending_outputs.size() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
